// File: design/tacs_pkg.sv
// Shared constants and types of the tangent-arc centre solver.
`timescale 1ns / 1ps
`default_nettype none
package tacs_pkg;

  // Fixed field widths of the slope, intercept and result words.
  localparam int SLOPE_W   = 32;
  localparam int OUT_W     = 32;
  localparam int ROOT_W    = 32;
  localparam int RAD_IN_W  = 2 * ROOT_W;

  // Centre offsets clamp at 2^OFS_BITS.
  localparam int OFS_BITS  = 50;
  localparam int QUO_W     = OFS_BITS + 1;
  localparam int CTR_W     = OFS_BITS + 2;

  // The replacement for a zero slope is 0.001, rounded to the nearest step.
  localparam int EPS_DIV   = 1000;
  localparam int EPS_ROUND = 500;

  // Segment kinds.
  typedef enum logic {
    OP_LINE = 1'b0,
    OP_ARC  = 1'b1
  } op_t;

  // Per-item flags carried alongside the divider.
  typedef struct packed {
    logic is_arc;
    logic degen;
    logic prev;
    logic dbl;
    logic line_right;
    logic below;
    logic neg_x;
    logic den_neg;
  } tacs_flags_t;

  // Resolved result flags carried alongside the square root.
  typedef struct packed {
    logic solved;
    logic degen;
    logic dbl_line;
    logic swap;
    logic to_right;
  } tacs_tail_t;

endpackage
`default_nettype wire

// File: design/tacs_if.sv
// Valid/ready channel interfaces for segment beats and result beats.
`timescale 1ns / 1ps
`default_nettype none
interface tacs_in_if import tacs_pkg::*; #(
  parameter int COORD_BITS = 12
) ();
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [COORD_BITS-1:0]   start_x;
  logic [COORD_BITS-1:0]   start_y;
  logic [COORD_BITS-1:0]   end_x;
  logic [COORD_BITS-1:0]   end_y;
  logic signed [SLOPE_W-1:0] tangent_slope;
  logic signed [SLOPE_W-1:0] tangent_offset;
  logic                    prev_to_right;
  logic [COORD_BITS-1:0]   last_start_x;
  logic [COORD_BITS-1:0]   last_start_y;

  modport source (output valid, op, start_x, start_y, end_x, end_y, tangent_slope,
                  tangent_offset, prev_to_right, last_start_x, last_start_y,
                  input ready);
  modport sink (input valid, op, start_x, start_y, end_x, end_y, tangent_slope,
                tangent_offset, prev_to_right, last_start_x, last_start_y,
                output ready);
endinterface

interface tacs_out_if import tacs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] center_x;
  logic signed [OUT_W-1:0] center_y;
  logic [OUT_W-1:0]        radius;
  logic                    degenerate;
  logic                    swap_ends;
  logic                    to_right;
  logic                    becomes_line;

  modport source (output valid, center_x, center_y, radius, degenerate, swap_ends,
                  to_right, becomes_line, input ready);
  modport sink (input valid, center_x, center_y, radius, degenerate, swap_ends,
                to_right, becomes_line, output ready);
endinterface
`default_nettype wire

// File: design/tacs_front.sv
// Front stages: slope fix-up, denominator, squared chord, degeneracy and tangent side.
`timescale 1ns / 1ps
`default_nettype none
module tacs_front import tacs_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic                      in_op,
  input  logic [COORD_BITS-1:0]     in_start_x,
  input  logic [COORD_BITS-1:0]     in_start_y,
  input  logic [COORD_BITS-1:0]     in_end_x,
  input  logic [COORD_BITS-1:0]     in_end_y,
  input  logic signed [SLOPE_W-1:0] in_slope,
  input  logic signed [SLOPE_W-1:0] in_offset,
  input  logic                      in_prev,
  input  logic [COORD_BITS-1:0]     in_last_x,
  input  logic [COORD_BITS-1:0]     in_last_y,
  output logic                      out_vld,
  output tacs_flags_t               out_flags,
  output logic [COORD_BITS-1:0]     out_x1,
  output logic [COORD_BITS-1:0]     out_y1,
  output logic [COORD_BITS-1:0]     out_x2,
  output logic [COORD_BITS-1:0]     out_y2,
  output logic [SLOPE_W+2*COORD_BITS:0] out_nx,
  output logic [2*COORD_BITS:0]     out_q,
  output logic [SLOPE_W+COORD_BITS+1:0] out_dd
);

  localparam int DW    = COORD_BITS + 1;
  localparam int QW    = 2 * COORD_BITS + 1;
  localparam int DENW  = SLOPE_W + COORD_BITS + 2;
  localparam int NXW   = SLOPE_W + QW;
  localparam int CMPW  = SLOPE_W + COORD_BITS + 3;
  localparam int EPS_Q = ((1 << FRAC_BITS) + EPS_ROUND) / EPS_DIV;
  localparam logic signed [SLOPE_W-1:0] EPS = (EPS_Q == 0) ? SLOPE_W'(1) : SLOPE_W'(EPS_Q);

  // Stage A registers.
  logic                      a_vld_r, a_op_r, a_prev_r, a_dbl_r, a_lright_r;
  logic [COORD_BITS-1:0]     a_x1_r, a_y1_r, a_x2_r, a_y2_r;
  logic signed [SLOPE_W-1:0] a_s_r, a_b_r;

  // Stage B signals and registers.
  logic signed [DW-1:0]         dx, dy;
  logic signed [DW+SLOPE_W-1:0] dxs;
  logic signed [2*DW-1:0]       sqx, sqy;
  logic signed [DENW-1:0]       den_nxt;
  logic [QW-1:0]                q_nxt;
  logic signed [SLOPE_W+COORD_BITS:0] sx2_nxt;
  logic                      b_vld_r, b_op_r, b_prev_r, b_dbl_r, b_lright_r;
  logic [COORD_BITS-1:0]     b_x1_r, b_y1_r, b_x2_r, b_y2_r;
  logic signed [SLOPE_W-1:0] b_s_r, b_b_r;
  logic signed [DENW-1:0]    b_den_r;
  logic [QW-1:0]             b_q_r;
  logic signed [SLOPE_W+COORD_BITS:0] b_sx2_r;

  // Stage C signals and registers.
  logic [DENW-1:0]          abs_den;
  logic [SLOPE_W-1:0]       abs_s;
  logic [DENW+9:0]          den1000;
  logic signed [CMPW-1:0]   y2k, rhs;
  logic [NXW-1:0]           nx_nxt;
  tacs_flags_t              flags_nxt;
  logic                     c_vld_r;
  tacs_flags_t              c_flags_r;
  logic [COORD_BITS-1:0]    c_x1_r, c_y1_r, c_x2_r, c_y2_r;
  logic [NXW-1:0]           c_nx_r;
  logic [QW-1:0]            c_q_r;
  logic [DENW-1:0]          c_dd_r;

  // Stage A: take the beat, replace a zero slope, test for a double click.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_op_r     <= in_op;
      a_x1_r     <= in_start_x;
      a_y1_r     <= in_start_y;
      a_x2_r     <= in_end_x;
      a_y2_r     <= in_end_y;
      a_s_r      <= (in_slope == '0) ? EPS : in_slope;
      a_b_r      <= in_offset;
      a_prev_r   <= in_prev;
      a_dbl_r    <= (in_start_x == in_last_x) && (in_start_y == in_last_y);
      a_lright_r <= in_end_x > in_start_x;
    end
  end

  // Stage B: denominator dx*S - K*dy, squared chord and S*x2.
  always_comb begin
    dx      = $signed({1'b0, a_x2_r}) - $signed({1'b0, a_x1_r});
    dy      = $signed({1'b0, a_y2_r}) - $signed({1'b0, a_y1_r});
    dxs     = dx * a_s_r;
    sqx     = dx * dx;
    sqy     = dy * dy;
    den_nxt = DENW'(dxs) - (DENW'(dy) <<< FRAC_BITS);
    q_nxt   = QW'($unsigned(sqx)) + QW'($unsigned(sqy));
    sx2_nxt = a_s_r * $signed({1'b0, a_x2_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_op_r     <= a_op_r;
      b_x1_r     <= a_x1_r;
      b_y1_r     <= a_y1_r;
      b_x2_r     <= a_x2_r;
      b_y2_r     <= a_y2_r;
      b_s_r      <= a_s_r;
      b_b_r      <= a_b_r;
      b_prev_r   <= a_prev_r;
      b_dbl_r    <= a_dbl_r;
      b_lright_r <= a_lright_r;
      b_den_r    <= den_nxt;
      b_q_r      <= q_nxt;
      b_sx2_r    <= sx2_nxt;
    end
  end

  // Stage C: magnitudes, degeneracy threshold, tangent side and x numerator.
  always_comb begin
    abs_den = b_den_r[DENW-1] ? DENW'(-b_den_r) : DENW'(b_den_r);
    abs_s   = b_s_r[SLOPE_W-1] ? SLOPE_W'(-b_s_r) : SLOPE_W'(b_s_r);
    den1000 = abs_den * 10'(EPS_DIV);
    y2k     = CMPW'($signed({1'b0, b_y2_r})) <<< FRAC_BITS;
    rhs     = CMPW'(b_sx2_r) + CMPW'(b_b_r);
    nx_nxt  = abs_s * b_q_r;
    flags_nxt.is_arc     = (b_op_r == OP_ARC);
    flags_nxt.degen      = den1000 <= (DENW+10)'(abs_s);
    flags_nxt.prev       = b_prev_r;
    flags_nxt.dbl        = b_dbl_r;
    flags_nxt.line_right = b_lright_r;
    flags_nxt.below      = y2k < rhs;
    flags_nxt.neg_x      = b_s_r[SLOPE_W-1] ^ b_den_r[DENW-1];
    flags_nxt.den_neg    = b_den_r[DENW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_flags_r <= flags_nxt;
      c_x1_r    <= b_x1_r;
      c_y1_r    <= b_y1_r;
      c_x2_r    <= b_x2_r;
      c_y2_r    <= b_y2_r;
      c_nx_r    <= nx_nxt;
      c_q_r     <= b_q_r;
      c_dd_r    <= {abs_den[DENW-2:0], 1'b0};
    end
  end

  assign out_vld   = c_vld_r;
  assign out_flags = c_flags_r;
  assign out_x1    = c_x1_r;
  assign out_y1    = c_y1_r;
  assign out_x2    = c_x2_r;
  assign out_y2    = c_y2_r;
  assign out_nx    = c_nx_r;
  assign out_q     = c_q_r;
  assign out_dd    = c_dd_r;

endmodule
`default_nettype wire

// File: design/tacs_div.sv
// Two-lane pipelined restoring divider with a shared divisor, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module tacs_div #(
  parameter int NW  = 73,
  parameter int DW  = 46,
  parameter int QB  = 51,
  parameter int SBW = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  logic [NW-1:0]  in_num_a,
  input  logic [NW-1:0]  in_num_b,
  input  logic [DW-1:0]  in_den,
  input  logic [SBW-1:0] in_sb,
  output logic           out_vld,
  output logic [QB-1:0]  out_quo_a,
  output logic [QB-1:0]  out_quo_b,
  output logic           out_ovf_a,
  output logic           out_ovf_b,
  output logic [SBW-1:0] out_sb
);

  logic [NW-1:0] hi_a, hi_b;
  logic          ovf_a0, ovf_b0;

  logic           vld_r   [0:QB];
  logic [DW-1:0]  den_r   [0:QB];
  logic [SBW-1:0] sb_r    [0:QB];
  logic [DW-1:0]  rem_a_r [0:QB];
  logic [DW-1:0]  rem_b_r [0:QB];
  logic [QB-1:0]  quo_a_r [0:QB];
  logic [QB-1:0]  quo_b_r [0:QB];
  logic [QB-1:0]  low_a_r [0:QB];
  logic [QB-1:0]  low_b_r [0:QB];
  logic           ovf_a_r [0:QB];
  logic           ovf_b_r [0:QB];

  // Entry: a quotient that needs more than QB bits is flagged as overflow.
  always_comb begin
    hi_a   = in_num_a >> QB;
    hi_b   = in_num_b >> QB;
    ovf_a0 = {{DW{1'b0}}, hi_a} >= {{NW{1'b0}}, in_den};
    ovf_b0 = {{DW{1'b0}}, hi_b} >= {{NW{1'b0}}, in_den};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0]   <= in_den;
      sb_r[0]    <= in_sb;
      rem_a_r[0] <= DW'(hi_a);
      rem_b_r[0] <= DW'(hi_b);
      quo_a_r[0] <= '0;
      quo_b_r[0] <= '0;
      low_a_r[0] <= in_num_a[QB-1:0];
      low_b_r[0] <= in_num_b[QB-1:0];
      ovf_a_r[0] <= ovf_a0;
      ovf_b_r[0] <= ovf_b0;
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [DW:0]   trial_a, trial_b, dext;
    logic          ge_a, ge_b;
    logic [DW-1:0] rem_a_nxt, rem_b_nxt;

    always_comb begin
      dext      = {1'b0, den_r[k-1]};
      trial_a   = {rem_a_r[k-1], low_a_r[k-1][QB-k]};
      trial_b   = {rem_b_r[k-1], low_b_r[k-1][QB-k]};
      ge_a      = trial_a >= dext;
      ge_b      = trial_b >= dext;
      rem_a_nxt = ge_a ? DW'(trial_a - dext) : DW'(trial_a);
      rem_b_nxt = ge_b ? DW'(trial_b - dext) : DW'(trial_b);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k]   <= den_r[k-1];
        sb_r[k]    <= sb_r[k-1];
        rem_a_r[k] <= rem_a_nxt;
        rem_b_r[k] <= rem_b_nxt;
        quo_a_r[k] <= {quo_a_r[k-1][QB-2:0], ge_a};
        quo_b_r[k] <= {quo_b_r[k-1][QB-2:0], ge_b};
        low_a_r[k] <= low_a_r[k-1];
        low_b_r[k] <= low_b_r[k-1];
        ovf_a_r[k] <= ovf_a_r[k-1];
        ovf_b_r[k] <= ovf_b_r[k-1];
      end
    end
  end

  assign out_vld   = vld_r[QB];
  assign out_quo_a = quo_a_r[QB];
  assign out_quo_b = quo_b_r[QB];
  assign out_ovf_a = ovf_a_r[QB];
  assign out_ovf_b = ovf_b_r[QB];
  assign out_sb    = sb_r[QB];

endmodule
`default_nettype wire

// File: design/tacs_sqrt.sv
// Pipelined integer square root of a 64-bit value, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module tacs_sqrt import tacs_pkg::*; #(
  parameter int SBW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [RAD_IN_W-1:0] in_rad,
  input  logic [SBW-1:0]      in_sb,
  output logic                out_vld,
  output logic [ROOT_W-1:0]   out_root,
  output logic [SBW-1:0]      out_sb
);

  localparam int REM_W = ROOT_W + 2;
  localparam int TRY_W = ROOT_W + 4;

  logic                vld_r  [0:ROOT_W];
  logic [RAD_IN_W-1:0] rad_r  [0:ROOT_W];
  logic [REM_W-1:0]    rem_r  [0:ROOT_W];
  logic [ROOT_W-1:0]   root_r [0:ROOT_W];
  logic [SBW-1:0]      sb_r   [0:ROOT_W];

  // Entry register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= in_rad;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      sb_r[0]   <= in_sb;
    end
  end

  // Each stage brings down two radicand bits and decides one root bit.
  for (genvar k = 1; k <= ROOT_W; k++) begin : g_step
    logic [TRY_W-1:0] trial, test;
    logic             ge;
    logic [REM_W-1:0] rem_nxt;

    always_comb begin
      trial   = {rem_r[k-1], rad_r[k-1][2*(ROOT_W-k)+1 -: 2]};
      test    = {2'b00, root_r[k-1], 2'b01};
      ge      = trial >= test;
      rem_nxt = ge ? REM_W'(trial - test) : REM_W'(trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= rad_r[k-1];
        rem_r[k]  <= rem_nxt;
        root_r[k] <= {root_r[k-1][ROOT_W-2:0], ge};
        sb_r[k]   <= sb_r[k-1];
      end
    end
  end

  assign out_vld  = vld_r[ROOT_W];
  assign out_root = root_r[ROOT_W];
  assign out_sb   = sb_r[ROOT_W];

endmodule
`default_nettype wire

// File: design/tangent_arc_center_solver_unit.sv
// Top level of the tangent-arc centre solver: front, divider, centre, radius and output.
//
// Usage: segment beats enter on in_ch and one result beat leaves on out_ch for each,
// in order. A line beat returns only its heading; an arc beat returns the circle
// centre, radius, endpoint order and new heading, or the degenerate and double-click
// flags when the arc cannot be solved.
// Pipeline: at the default sizes, 3 front stages, 52 divider stages (one per bit of the
// 51-bit clamped quotient, plus entry), 3 stages for centre, distances and squares,
// 33 square-root stages (one per root bit, plus entry) and the output register.
// Throughput: one beat per cycle while no result is held at the output; every stage
// holds one item and all stages advance together.
// Stall: while a result waits on out_ch, the whole pipeline holds and in_ch.ready is
// low; as soon as the result is taken or absent, a new beat is accepted in the same
// cycle as the old one leaves.
// Reset: synchronous, active low; all valid bits clear, so no result appears until a
// beat has passed through the full pipeline.
`timescale 1ns / 1ps
`default_nettype none
module tangent_arc_center_solver_unit import tacs_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  tacs_in_if.sink     in_ch,
  tacs_out_if.source  out_ch
);

  localparam int QW      = 2 * COORD_BITS + 1;
  localparam int DENW    = SLOPE_W + COORD_BITS + 2;
  localparam int NXW     = SLOPE_W + QW;
  localparam int NW      = NXW + FRAC_BITS;
  localparam int FLAGS_W = $bits(tacs_flags_t);
  localparam int TAIL_W  = $bits(tacs_tail_t);
  localparam int SBD_W   = FLAGS_W + 4 * COORD_BITS;
  localparam int SBS_W   = 1 + TAIL_W + 2 * OUT_W;
  localparam int EXW     = CTR_W + 1;
  localparam logic [QUO_W-1:0] OFS_LIM = {1'b1, {OFS_BITS{1'b0}}};

  // Saturate a centre coordinate to a signed 32-bit word.
  function automatic logic signed [OUT_W-1:0] sat_ctr(input logic signed [CTR_W-1:0] v);
    logic pos_ovf;
    logic neg_ovf;
    pos_ovf = !v[CTR_W-1] && (|v[CTR_W-2:OUT_W-1]);
    neg_ovf = v[CTR_W-1] && !(&v[CTR_W-2:OUT_W-1]);
    if (pos_ovf) begin
      sat_ctr = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (neg_ovf) begin
      sat_ctr = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat_ctr = v[OUT_W-1:0];
    end
  endfunction

  logic en;

  // Front outputs.
  logic                  fr_vld;
  tacs_flags_t           fr_flags;
  logic [COORD_BITS-1:0] fr_x1, fr_y1, fr_x2, fr_y2;
  logic [NXW-1:0]        fr_nx;
  logic [QW-1:0]         fr_q;
  logic [DENW-1:0]       fr_dd;

  // Divider outputs.
  logic                  dv_vld, dv_ovf_a, dv_ovf_b;
  logic [QUO_W-1:0]      dv_quo_a, dv_quo_b;
  logic [SBD_W-1:0]      dv_sb;
  tacs_flags_t           dv_flags;
  logic [COORD_BITS-1:0] dv_x1, dv_y1, dv_x2, dv_y2;

  // Centre stage.
  logic [QUO_W-1:0]        ux, uy;
  logic signed [CTR_W-1:0] uxs, uys, x1k, y1k, cx_nxt, cy_nxt;
  logic                    e_vld_r;
  tacs_flags_t             e_flags_r;
  logic signed [CTR_W-1:0] e_cx_r, e_cy_r;
  logic [COORD_BITS-1:0]   e_x2_r, e_y2_r;

  // Distance stage.
  logic signed [CTR_W-1:0] x2k, y2k;
  logic signed [EXW-1:0]   ddx, ddy;
  logic [EXW-1:0]          ex, ey;
  logic                    swap, arc_right;
  tacs_tail_t              tail_nxt;
  logic                    f_vld_r, f_big_r;
  logic [OUT_W-1:0]        f_ex_r, f_ey_r;
  tacs_tail_t              f_tail_r;
  logic signed [OUT_W-1:0] f_cx_r, f_cy_r;

  // Square stage.
  logic                    g_vld_r, g_big_r;
  logic [RAD_IN_W-1:0]     g_exx_r, g_eyy_r;
  tacs_tail_t              g_tail_r;
  logic signed [OUT_W-1:0] g_cx_r, g_cy_r;
  logic [RAD_IN_W:0]       sum;
  logic                    rad_force;

  // Square-root outputs.
  logic                    sq_vld, sq_force;
  logic [ROOT_W-1:0]       sq_root;
  logic [SBS_W-1:0]        sq_sb;
  tacs_tail_t              sq_tail;
  logic signed [OUT_W-1:0] sq_cx, sq_cy;

  // Output register.
  logic                    out_vld_r;
  logic signed [OUT_W-1:0] out_cx_r, out_cy_r;
  logic [OUT_W-1:0]        out_rad_r;
  logic                    out_degen_r, out_swap_r, out_right_r, out_dbl_r;

  // The whole pipeline advances unless a result is held at the output.
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  tacs_front #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (in_ch.valid),
    .in_op     (in_ch.op),
    .in_start_x(in_ch.start_x),
    .in_start_y(in_ch.start_y),
    .in_end_x  (in_ch.end_x),
    .in_end_y  (in_ch.end_y),
    .in_slope  (in_ch.tangent_slope),
    .in_offset (in_ch.tangent_offset),
    .in_prev   (in_ch.prev_to_right),
    .in_last_x (in_ch.last_start_x),
    .in_last_y (in_ch.last_start_y),
    .out_vld   (fr_vld),
    .out_flags (fr_flags),
    .out_x1    (fr_x1),
    .out_y1    (fr_y1),
    .out_x2    (fr_x2),
    .out_y2    (fr_y2),
    .out_nx    (fr_nx),
    .out_q     (fr_q),
    .out_dd    (fr_dd)
  );

  tacs_div #(
    .NW (NW),
    .DW (DENW),
    .QB (QUO_W),
    .SBW(SBD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (fr_vld),
    .in_num_a ({fr_nx, {FRAC_BITS{1'b0}}}),
    .in_num_b (NW'({fr_q, {(2*FRAC_BITS){1'b0}}})),
    .in_den   (fr_dd),
    .in_sb    ({fr_flags, fr_x1, fr_y1, fr_x2, fr_y2}),
    .out_vld  (dv_vld),
    .out_quo_a(dv_quo_a),
    .out_quo_b(dv_quo_b),
    .out_ovf_a(dv_ovf_a),
    .out_ovf_b(dv_ovf_b),
    .out_sb   (dv_sb)
  );

  assign {dv_flags, dv_x1, dv_y1, dv_x2, dv_y2} = dv_sb;

  // Centre stage: clamp the offsets and add them to the start point.
  always_comb begin
    ux     = (dv_ovf_a || dv_quo_a > OFS_LIM) ? OFS_LIM : dv_quo_a;
    uy     = (dv_ovf_b || dv_quo_b > OFS_LIM) ? OFS_LIM : dv_quo_b;
    uxs    = $signed({1'b0, ux});
    uys    = $signed({1'b0, uy});
    x1k    = $signed(CTR_W'({dv_x1, {FRAC_BITS{1'b0}}}));
    y1k    = $signed(CTR_W'({dv_y1, {FRAC_BITS{1'b0}}}));
    cx_nxt = x1k + (dv_flags.neg_x ? -uxs : uxs);
    cy_nxt = y1k + (dv_flags.den_neg ? uys : -uys);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_flags_r <= dv_flags;
      e_cx_r    <= cx_nxt;
      e_cy_r    <= cy_nxt;
      e_x2_r    <= dv_x2;
      e_y2_r    <= dv_y2;
    end
  end

  // Distance stage: end point minus centre, saturation and the new heading.
  always_comb begin
    x2k       = $signed(CTR_W'({e_x2_r, {FRAC_BITS{1'b0}}}));
    y2k       = $signed(CTR_W'({e_y2_r, {FRAC_BITS{1'b0}}}));
    ddx       = EXW'(x2k) - EXW'(e_cx_r);
    ddy       = EXW'(y2k) - EXW'(e_cy_r);
    ex        = ddx[EXW-1] ? EXW'(-ddx) : EXW'(ddx);
    ey        = ddy[EXW-1] ? EXW'(-ddy) : EXW'(ddy);
    swap      = e_flags_r.prev != e_flags_r.below;
    arc_right = swap ? (y2k < e_cy_r) : (y2k > e_cy_r);
    tail_nxt.solved   = e_flags_r.is_arc && !e_flags_r.degen;
    tail_nxt.degen    = e_flags_r.is_arc && e_flags_r.degen;
    tail_nxt.dbl_line = e_flags_r.is_arc && e_flags_r.degen && e_flags_r.dbl;
    tail_nxt.swap     = e_flags_r.is_arc && !e_flags_r.degen && swap;
    if (!e_flags_r.is_arc) begin
      tail_nxt.to_right = e_flags_r.line_right;
    end else if (e_flags_r.degen) begin
      tail_nxt.to_right = e_flags_r.prev;
    end else begin
      tail_nxt.to_right = arc_right;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_ex_r   <= ex[OUT_W-1:0];
      f_ey_r   <= ey[OUT_W-1:0];
      f_big_r  <= (|ex[EXW-1:OUT_W]) || (|ey[EXW-1:OUT_W]);
      f_tail_r <= tail_nxt;
      f_cx_r   <= sat_ctr(e_cx_r);
      f_cy_r   <= sat_ctr(e_cy_r);
    end
  end

  // Square stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r <= f_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_exx_r  <= f_ex_r * f_ex_r;
      g_eyy_r  <= f_ey_r * f_ey_r;
      g_big_r  <= f_big_r;
      g_tail_r <= f_tail_r;
      g_cx_r   <= f_cx_r;
      g_cy_r   <= f_cy_r;
    end
  end

  // A sum beyond 64 bits, or a distance that does not fit in 32 bits, forces the radius to its maximum.
  assign sum       = {1'b0, g_exx_r} + {1'b0, g_eyy_r};
  assign rad_force = g_big_r || sum[RAD_IN_W];

  tacs_sqrt #(
    .SBW(SBS_W)
  ) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (g_vld_r),
    .in_rad  (sum[RAD_IN_W-1:0]),
    .in_sb   ({rad_force, g_tail_r, g_cx_r, g_cy_r}),
    .out_vld (sq_vld),
    .out_root(sq_root),
    .out_sb  (sq_sb)
  );

  assign {sq_force, sq_tail, sq_cx, sq_cy} = sq_sb;

  // Output register: unsolved items report zero geometry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_cx_r    <= sq_tail.solved ? sq_cx : '0;
      out_cy_r    <= sq_tail.solved ? sq_cy : '0;
      out_rad_r   <= sq_tail.solved ? (sq_force ? '1 : sq_root) : '0;
      out_degen_r <= sq_tail.degen;
      out_swap_r  <= sq_tail.swap;
      out_right_r <= sq_tail.to_right;
      out_dbl_r   <= sq_tail.dbl_line;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.center_x     = out_cx_r;
  assign out_ch.center_y     = out_cy_r;
  assign out_ch.radius       = out_rad_r;
  assign out_ch.degenerate   = out_degen_r;
  assign out_ch.swap_ends    = out_swap_r;
  assign out_ch.to_right     = out_right_r;
  assign out_ch.becomes_line = out_dbl_r;

`ifndef SYNTH
  // A degenerate arc carries no geometry.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_degen_r |->
      out_cx_r == '0 && out_cy_r == '0 && out_rad_r == '0 && !out_swap_r)
    else $error("degenerate result carries geometry");

  // A double click is only reported for a degenerate arc.
  a_dbl_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_dbl_r |-> out_degen_r)
    else $error("double click without degenerate arc");

  // The input is held off only while a result waits at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_vld_r && !out_ch.ready)
    else $error("input stalled without an output stall");

  // A held result is still presented in the next cycle.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(out_rad_r))
    else $error("held result lost");
`endif

endmodule
`default_nettype wire
